>>> rtl/kpd_pkg.sv
// Shared types, constants and the navigation encoder of the keypad event detector.
`default_nettype none
package kpd_pkg;

  localparam int unsigned KIND_W    = 3;
  localparam int unsigned PIN_W     = 9;
  localparam int unsigned ELAPSED_W = 10;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned THRESH_W  = 16;
  localparam int unsigned NAV_W     = 3;
  localparam int unsigned NAV_CODES = 8;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd1000;

  typedef enum logic [KIND_W-1:0] {
    KIND_SCAN         = 3'd0,
    KIND_TAKE_PRESS   = 3'd1,
    KIND_TAKE_RELEASE = 3'd2,
    KIND_PEEK_HELD    = 3'd3,
    KIND_TAKE_LONG    = 3'd4
  } kind_e;

  // key index for each navigation code, highest priority first
  localparam logic [IDX_W-1:0] NAV_KEY_OF_CODE [NAV_CODES] = '{
    4'd3, 4'd1, 4'd0, 4'd2, 4'd6, 4'd5, 4'd4, 4'd7
  };

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [PIN_W-1:0]     raw_pins;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic [IDX_W-1:0]     key_index;
  } item_t;

  typedef struct packed {
    logic             answer;
    logic [PIN_W-1:0] held_mask;
  } bank_res_t;

  typedef struct packed {
    logic             active;
    logic [NAV_W-1:0] code;
  } nav_t;

  // lowest code whose key is held wins
  function automatic nav_t nav_encode(input logic [PIN_W-1:0] held);
    nav_t res;
    res.active = 1'b0;
    res.code   = '0;
    for (int c = NAV_CODES - 1; c >= 0; c--) begin
      if (held[NAV_KEY_OF_CODE[c]]) begin
        res.active = 1'b1;
        res.code   = NAV_W'(c);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/keypad_event_detector_unit.sv
// Keypad event detector: a transaction passes the input register, then the result register, before result valid.
// Throughput one transaction per cycle: input register, key bank update, result register.
// Stalls only when the result register is full and out_ready_i is low.
// rst_ni (async, active low) clears all key state, both valid flags and sets the
// long-press threshold to 1000 ms.
`default_nettype none
module keypad_event_detector_unit #(
  parameter int unsigned NUM_KEYS   = 9,
  parameter int unsigned HOLD_WIDTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [kpd_pkg::KIND_W-1:0]       kind_i,
  input  wire logic [kpd_pkg::PIN_W-1:0]        raw_pins_i,
  input  wire logic [kpd_pkg::ELAPSED_W-1:0]    elapsed_ms_i,
  input  wire logic [kpd_pkg::IDX_W-1:0]        key_index_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [kpd_pkg::THRESH_W-1:0]     cfg_wdata_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  answer_o,
  output logic [kpd_pkg::PIN_W-1:0]             held_mask_o,
  output logic                                  nav_active_o,
  output logic [kpd_pkg::NAV_W-1:0]             nav_code_o
);

  logic                          in_vld_q, out_vld_q;
  kpd_pkg::item_t                item_q;
  logic [kpd_pkg::THRESH_W-1:0]  thresh_q;
  logic                          advance, fire;
  kpd_pkg::bank_res_t            bank_res;
  kpd_pkg::nav_t                 nav;
  logic                          answer_q, nav_active_q;
  logic [kpd_pkg::PIN_W-1:0]     held_q;
  logic [kpd_pkg::NAV_W-1:0]     nav_code_q;

  assign advance    = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= kpd_pkg::THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.kind       <= kind_i;
      item_q.raw_pins   <= raw_pins_i;
      item_q.elapsed_ms <= elapsed_ms_i;
      item_q.key_index  <= key_index_i;
    end
  end

  kpd_key_bank #(
    .NUM_KEYS   (NUM_KEYS),
    .HOLD_WIDTH (HOLD_WIDTH)
  ) u_bank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (item_q),
    .threshold_i (thresh_q),
    .res_o       (bank_res)
  );

  assign nav = kpd_pkg::nav_encode(bank_res.held_mask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      answer_q     <= bank_res.answer;
      held_q       <= bank_res.held_mask;
      nav_active_q <= nav.active;
      nav_code_q   <= nav.code;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign answer_o     = answer_q;
  assign held_mask_o  = held_q;
  assign nav_active_o = nav_active_q;
  assign nav_code_o   = nav_code_q;

endmodule
`default_nettype wire

>>> rtl/kpd_key_bank.sv
// Per-key state (level, edge flags, long-press mark, hold counter) and query logic.
`default_nettype none
module kpd_key_bank #(
  parameter int unsigned NUM_KEYS   = 9,
  parameter int unsigned HOLD_WIDTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              fire_i,
  input  wire kpd_pkg::item_t                    item_i,
  input  wire logic [kpd_pkg::THRESH_W-1:0]      threshold_i,
  output kpd_pkg::bank_res_t                     res_o
);

  localparam int unsigned SUM_W =
    ((HOLD_WIDTH > kpd_pkg::ELAPSED_W) ? HOLD_WIDTH : kpd_pkg::ELAPSED_W) + 1;
  localparam int unsigned CMP_W =
    (HOLD_WIDTH > kpd_pkg::THRESH_W) ? HOLD_WIDTH : kpd_pkg::THRESH_W;

  logic [NUM_KEYS-1:0] level_d;
  logic [NUM_KEYS-1:0] ans_vec;

  logic is_scan, is_press, is_release, is_peek, is_long;

  assign is_scan    = (item_i.kind == kpd_pkg::KIND_SCAN);
  assign is_press   = (item_i.kind == kpd_pkg::KIND_TAKE_PRESS);
  assign is_release = (item_i.kind == kpd_pkg::KIND_TAKE_RELEASE);
  assign is_peek    = (item_i.kind == kpd_pkg::KIND_PEEK_HELD);
  assign is_long    = (item_i.kind == kpd_pkg::KIND_TAKE_LONG);

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_key
    logic                  level_q, press_q, release_q, fired_q;
    logic                  press_d, release_d, fired_d, lvl_d;
    logic [HOLD_WIDTH-1:0] hold_q, hold_d;
    logic                  pin_held;
    logic                  hit;
    logic [SUM_W-1:0]      sum;
    logic                  long_ok;
    logic                  ans;

    if (i < kpd_pkg::PIN_W) begin : g_pin
      assign pin_held = ~item_i.raw_pins[i];
    end else begin : g_nopin
      assign pin_held = 1'b0;
    end

    assign hit = (32'(item_i.key_index) == 32'(i));
    assign sum = SUM_W'(hold_q) + SUM_W'(item_i.elapsed_ms);
    assign long_ok = level_q && !fired_q &&
                     (CMP_W'(hold_q) >= CMP_W'(threshold_i));

    always_comb begin
      lvl_d     = level_q;
      press_d   = press_q;
      release_d = release_q;
      fired_d   = fired_q;
      hold_d    = hold_q;
      ans       = 1'b0;
      if (is_scan) begin
        lvl_d     = pin_held;
        press_d   = pin_held & ~level_q;
        release_d = level_q & ~pin_held;
        fired_d   = fired_q & pin_held;
        if (!pin_held) begin
          hold_d = '0;
        end else if (|sum[SUM_W-1:HOLD_WIDTH]) begin
          hold_d = '1;
        end else begin
          hold_d = sum[HOLD_WIDTH-1:0];
        end
      end else if (hit) begin
        if (is_press) begin
          ans     = press_q;
          press_d = 1'b0;
        end else if (is_release) begin
          ans       = release_q;
          release_d = 1'b0;
        end else if (is_peek) begin
          ans = level_q;
        end else if (is_long) begin
          ans = long_ok;
          if (long_ok) begin
            fired_d = 1'b1;
          end
        end
      end
    end

    assign level_d[i] = lvl_d;
    assign ans_vec[i] = ans;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        level_q   <= 1'b0;
        press_q   <= 1'b0;
        release_q <= 1'b0;
        fired_q   <= 1'b0;
        hold_q    <= '0;
      end else if (fire_i) begin
        level_q   <= lvl_d;
        press_q   <= press_d;
        release_q <= release_d;
        fired_q   <= fired_d;
        hold_q    <= hold_d;
      end
    end
  end

  // held mask after this transaction; keys beyond NUM_KEYS read as released
  for (genvar j = 0; j < kpd_pkg::PIN_W; j++) begin : g_mask
    if (j < NUM_KEYS) begin : g_have
      assign res_o.held_mask[j] = level_d[j];
    end else begin : g_none
      assign res_o.held_mask[j] = 1'b0;
    end
  end

  assign res_o.answer = |ans_vec;

endmodule
`default_nettype wire
